@@ design/sopt_pkg.sv @@
package sopt_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_KILL  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_KILL  = 2'd1,
    KIND_FIRED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_FLUSH = 2'd2
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic step;
    logic start_take;
    logic start_full;
    logic kill_ack;
    logic kill_clear;
    logic fire;
    logic push_pend;
    logic push_last;
  } sopt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_op;
    op_t        cur_op;
    logic       hit;
    logic       idx_last;
    logic       pend_valid;
    logic       out_free;
  } sopt_stat_t;

endpackage

@@ design/sopt_if.sv @@
interface sopt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] now_ms;
  logic [31:0] delay_ms;
  logic        periodic;
  logic [31:0] user_word;
  logic [31:0] target_id;

  modport source (
    output valid, operation, now_ms, delay_ms, periodic, user_word, target_id,
    input  ready
  );
  modport sink (
    input  valid, operation, now_ms, delay_ms, periodic, user_word, target_id,
    output ready
  );
endinterface

interface sopt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] timer_id;
  logic [31:0] fired_user;
  logic        last;

  modport source (
    output valid, kind, timer_id, fired_user, last,
    input  ready
  );
  modport sink (
    input  valid, kind, timer_id, fired_user, last,
    output ready
  );
endinterface

@@ design/slotted_oneshot_periodic_timers.sv @@
// Sixteen millisecond timer slots driven one word at a time. Each input word
// carries an operation and the current time: start takes the lowest free slot,
// gives it the next 32-bit id (zero is never used; a full table answers id 0)
// and sets its due time to now plus the delay, a zero delay counting as one;
// kill frees the lowest active slot with the given id and always answers with
// one acknowledge; tick walks the slots in order and reports every active slot
// whose due time has passed (wrap-safe signed difference), reloading periodic
// slots and freeing one-shot slots, with last set on the final report and no
// report at all when nothing is due. Operation code 3 is dropped silently.
// Timing: a sequencer visits one slot per cycle through a single compare and
// add, unless the output side holds off a result, after an accept step for
// the item: start and kill stop at the first hit, and tick visits all 16
// slots and then takes a closing step for the last report. One result register
// sits at the output, so a new word is taken while the last result still waits.
module slotted_oneshot_periodic_timers (
  input logic        clk,
  input logic        rst,
  sopt_in_if.sink    in_ch,
  sopt_out_if.source out_ch
);
  import sopt_pkg::*;

  sopt_cmd_t  cmd;   // sequencer commands
  sopt_stat_t stat;  // slot and handshake status

  // sequencer: idle / per-slot scan / closing report of a tick
  sopt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // slot table, id counter, held fired word and output register
  sopt_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

@@ design/sopt_ctrl.sv @@
module sopt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  sopt_pkg::sopt_stat_t stat,
  output sopt_pkg::sopt_cmd_t  cmd
);
  import sopt_pkg::*;

  state_t state;
  state_t state_next;
  logic   tick_stall;
  logic   item_done;

  // a due slot cannot be taken while the held one still waits for the output
  assign tick_stall = stat.hit && stat.pend_valid && !stat.out_free;
  // start and kill finish on a hit or at the last slot
  assign item_done  = stat.hit || stat.idx_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (stat.in_valid && (stat.in_op inside {OP_START, OP_KILL, OP_TICK})) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        case (stat.cur_op)
          OP_START, OP_KILL: begin
            if (item_done && stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          OP_TICK: begin
            if (!tick_stall && stat.idx_last) begin
              state_next = S_FLUSH;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FLUSH: begin
        if (!stat.pend_valid || stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = stat.in_valid;
      end
      S_SCAN: begin
        case (stat.cur_op)
          OP_START: begin
            if (stat.hit) begin
              cmd.start_take = stat.out_free;
            end else if (stat.idx_last) begin
              cmd.start_full = stat.out_free;
            end else begin
              cmd.step = 1'b1;
            end
          end
          OP_KILL: begin
            if (item_done) begin
              cmd.kill_ack   = stat.out_free;
              cmd.kill_clear = stat.out_free && stat.hit;
            end else begin
              cmd.step = 1'b1;
            end
          end
          OP_TICK: begin
            if (!tick_stall) begin
              cmd.fire      = stat.hit;
              cmd.push_pend = stat.hit && stat.pend_valid;
              cmd.step      = !stat.idx_last;
            end
          end
          default: cmd = '0;
        endcase
      end
      S_FLUSH: begin
        cmd.push_pend = stat.pend_valid && stat.out_free;
        cmd.push_last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ design/sopt_datapath.sv @@
module sopt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  sopt_in_if.sink              in_ch,
  sopt_out_if.source           out_ch,
  input  sopt_pkg::sopt_cmd_t  cmd,
  output sopt_pkg::sopt_stat_t stat
);
  import sopt_pkg::*;

  // latched item
  op_t         cur_op;
  logic [31:0] now_q;
  logic [31:0] delay_q;
  logic [31:0] start_due;
  logic        per_q;
  logic [31:0] user_q;
  logic [31:0] target_q;

  logic [IDX_W-1:0] idx;
  logic [31:0]      next_id;

  // slot table
  logic [SLOTS-1:0] slot_active;
  logic [31:0]      slot_id [SLOTS];
  logic [31:0]      slot_delay [SLOTS];
  logic             slot_periodic [SLOTS];
  logic [31:0]      slot_user [SLOTS];
  logic [31:0]      slot_due [SLOTS];

  // fired word held until the next one shows whether it was the last
  logic        pend_valid;
  logic [31:0] pend_id;
  logic [31:0] pend_user;

  // output register
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_id;
  logic [31:0] out_user;
  logic        out_last;

  logic [31:0] due_diff;
  logic        is_free;
  logic        is_match;
  logic        is_due;
  logic        hit;
  logic        out_free;
  logic        push;
  logic [31:0] delay_eff;

  assign delay_eff = (in_ch.delay_ms == 32'd0) ? 32'd1 : in_ch.delay_ms;
  assign due_diff  = now_q - slot_due[idx];
  assign is_free   = !slot_active[idx];
  assign is_match  = slot_active[idx] && (slot_id[idx] == target_q);
  assign is_due    = slot_active[idx] && !due_diff[31];

  always_comb begin
    case (cur_op)
      OP_START: hit = is_free;
      OP_KILL:  hit = is_match;
      OP_TICK:  hit = is_due;
      default:  hit = 1'b0;
    endcase
  end

  assign out_free = !out_valid || out_ch.ready;
  assign push     = cmd.start_take || cmd.start_full || cmd.kill_ack || cmd.push_pend;

  assign stat.in_valid   = in_ch.valid;
  assign stat.in_op      = in_ch.operation;
  assign stat.cur_op     = cur_op;
  assign stat.hit        = hit;
  assign stat.idx_last   = (idx == IDX_LAST);
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  assign in_ch.ready       = cmd.in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.kind       = out_kind;
  assign out_ch.timer_id   = out_id;
  assign out_ch.fired_user = out_user;
  assign out_ch.last       = out_last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      next_id     <= 32'd1;
      slot_active <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.start_take) begin
        slot_active[idx] <= 1'b1;
        next_id          <= (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
      end
      if (cmd.kill_clear) begin
        slot_active[idx] <= 1'b0;
      end
      if (cmd.fire && !slot_periodic[idx]) begin
        slot_active[idx] <= 1'b0;
      end
      if (cmd.load) begin
        pend_valid <= 1'b0;
      end else if (cmd.fire) begin
        pend_valid <= 1'b1;
      end else if (cmd.push_pend) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_op    <= op_t'(in_ch.operation);
      now_q     <= in_ch.now_ms;
      delay_q   <= delay_eff;
      start_due <= in_ch.now_ms + delay_eff;
      per_q     <= in_ch.periodic;
      user_q    <= in_ch.user_word;
      target_q  <= in_ch.target_id;
    end
    if (cmd.start_take) begin
      slot_id[idx]       <= next_id;
      slot_delay[idx]    <= delay_q;
      slot_periodic[idx] <= per_q;
      slot_user[idx]     <= user_q;
      slot_due[idx]      <= start_due;
    end
    if (cmd.fire) begin
      pend_id   <= slot_id[idx];
      pend_user <= slot_user[idx];
      if (slot_periodic[idx]) begin
        slot_due[idx] <= now_q + slot_delay[idx];
      end
    end
    if (cmd.start_take) begin
      out_kind <= KIND_START;
      out_id   <= next_id;
      out_user <= 32'd0;
      out_last <= 1'b1;
    end else if (cmd.start_full) begin
      out_kind <= KIND_START;
      out_id   <= 32'd0;
      out_user <= 32'd0;
      out_last <= 1'b1;
    end else if (cmd.kill_ack) begin
      out_kind <= KIND_KILL;
      out_id   <= 32'd0;
      out_user <= 32'd0;
      out_last <= 1'b1;
    end else if (cmd.push_pend) begin
      out_kind <= KIND_FIRED;
      out_id   <= pend_id;
      out_user <= pend_user;
      out_last <= cmd.push_last;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> out_free)
    else $error("word pushed over an untaken output word");
  a_pend_held: assert property (@(posedge clk) disable iff (rst) cmd.push_pend |-> pend_valid)
    else $error("fired word pushed with nothing held");
  a_take_free: assert property (@(posedge clk) disable iff (rst)
                                cmd.start_take |-> !slot_active[idx])
    else $error("start took a busy slot");
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
                                 cmd.start_take |=> next_id != 32'd0)
    else $error("id counter reached zero");

endmodule
